### rtl/bfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int WCNT_W     = WORD_AW + 1;
    localparam int FRAME_W    = 12;
    localparam int CFG_W      = 13;
    localparam int GRP_SIZE   = 8;
    localparam int SEL_W      = $clog2(GRP_SIZE);
    localparam int GRP_N      = MAP_WORDS / GRP_SIZE;
    localparam int GRP_W      = WORD_AW - SEL_W;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(4096);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [FRAME_W-1:0] current_frame;
        logic               kernel_page;
        logic               writable;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic               present_bit;
        logic               rw_bit;
        logic               user_bit;
        logic [1:0]         status;
        logic               in_use;
    } t_rsp;

    typedef struct packed {
        logic               vld;
        logic [WORD_AW-1:0] word;
        logic               full;
    } t_full_upd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORD,
        S_MODIFY,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### rtl/bfa_map_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_map_ram
// Used/free bitmap storage: one 32-bit word per row, registered read,
// per-row valid bits so rows never written read as all free.
// ----------------------------------------------------------------------------
module bfa_map_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rd_en,
    input  wire logic [bfa_pkg::WORD_AW-1:0]   i_rd_addr,
    input  wire logic                          i_wr_en,
    input  wire logic [bfa_pkg::WORD_AW-1:0]   i_wr_addr,
    input  wire logic [bfa_pkg::WORD_BITS-1:0] i_wr_data,
    output logic      [bfa_pkg::WORD_BITS-1:0] o_rd_data
);

    logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];
    logic [bfa_pkg::WORD_BITS-1:0] r_rd_data;
    logic [bfa_pkg::MAP_WORDS-1:0] r_vld;
    logic                          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    a_no_same_row_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en && i_wr_en |-> i_rd_addr != i_wr_addr)
        else $error("read and write of one row in one cycle");

    a_unwritten_reads_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en && !r_vld[i_rd_addr] |=> o_rd_data == '0)
        else $error("unwritten row did not read as free");

    a_write_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_vld[$past(i_wr_addr)])
        else $error("row valid bit not set after write");

endmodule
`default_nettype wire

### rtl/bfa_free_find.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_free_find
// Word summary (one full flag per bitmap word) and a two-level search for
// the lowest word with a free frame: group of 8 words, then word in group.
// ----------------------------------------------------------------------------
module bfa_free_find (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bfa_pkg::t_full_upd          i_upd,
    input  wire logic [bfa_pkg::WCNT_W-1:0]  i_words,
    output logic                             o_hit,
    output logic      [bfa_pkg::WORD_AW-1:0] o_word
);

    logic [bfa_pkg::MAP_WORDS-1:0] r_full;
    logic [bfa_pkg::MAP_WORDS-1:0] avail;
    logic [bfa_pkg::GRP_N-1:0]     grp_any;
    logic [bfa_pkg::GRP_W-1:0]     grp_sel;
    logic                          grp_hit;
    logic [bfa_pkg::GRP_W-1:0]     r_grp;
    logic                          r_hit;
    logic [bfa_pkg::GRP_SIZE-1:0]  sub;
    logic [bfa_pkg::SEL_W-1:0]     sel;

    always_comb begin
        for (int w = 0; w < bfa_pkg::MAP_WORDS; w++) begin
            avail[w] = !r_full[w] && (bfa_pkg::WCNT_W'(w) < i_words);
        end
        for (int g = 0; g < bfa_pkg::GRP_N; g++) begin
            grp_any[g] = |avail[g*bfa_pkg::GRP_SIZE +: bfa_pkg::GRP_SIZE];
        end
    end

    always_comb begin
        grp_sel = '0;
        grp_hit = 1'b0;
        for (int g = bfa_pkg::GRP_N - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                grp_sel = bfa_pkg::GRP_W'(g);
                grp_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
            r_hit  <= 1'b0;
        end else begin
            if (i_upd.vld) begin
                r_full[i_upd.word] <= i_upd.full;
            end
            r_hit <= grp_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= grp_sel;
    end

    always_comb begin
        sub = avail[{r_grp, {bfa_pkg::SEL_W{1'b0}}} +: bfa_pkg::GRP_SIZE];
        sel = '0;
        for (int j = bfa_pkg::GRP_SIZE - 1; j >= 0; j--) begin
            if (sub[j]) begin
                sel = bfa_pkg::SEL_W'(j);
            end
        end
    end

    assign o_hit  = r_hit;
    assign o_word = {r_grp, sel};

    a_full_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd.vld |=> r_full[$past(i_upd.word)] == $past(i_upd.full))
        else $error("word summary not updated");

    a_hit_has_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grp_hit |-> grp_any[grp_sel])
        else $error("selected group has no free word");

    a_no_hit_all_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !grp_hit |-> avail == '0)
        else $error("free word missed by search");

endmodule
`default_nettype wire

### rtl/bfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Request sequencer: read-modify-write of bitmap words, result build and
// output register.
// ----------------------------------------------------------------------------
module bfa_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bfa_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_req_valid,
    input  wire bfa_pkg::t_req                 i_req,
    output logic                               o_req_stall,
    output logic                               o_rsp_valid,
    output bfa_pkg::t_rsp                      o_rsp,
    input  wire logic                          i_rsp_stall,
    output logic                               o_rd_en,
    output logic      [bfa_pkg::WORD_AW-1:0]   o_rd_addr,
    output logic                               o_wr_en,
    output logic      [bfa_pkg::WORD_AW-1:0]   o_wr_addr,
    output logic      [bfa_pkg::WORD_BITS-1:0] o_wr_data,
    input  wire logic [bfa_pkg::WORD_BITS-1:0] i_rd_data,
    output bfa_pkg::t_full_upd                 o_upd,
    output logic      [bfa_pkg::WCNT_W-1:0]    o_words,
    input  wire logic                          i_hit,
    input  wire logic [bfa_pkg::WORD_AW-1:0]   i_word
);

    bfa_pkg::t_state               r_state, n_state;
    logic [bfa_pkg::CFG_W-1:0]     r_active;
    logic [1:0]                    r_op;
    logic [bfa_pkg::FRAME_W-1:0]   r_cur;
    logic                          r_kern;
    logic                          r_wr;
    logic [bfa_pkg::WORD_AW-1:0]   r_word;
    bfa_pkg::t_rsp                 r_res, n_res;
    bfa_pkg::t_rsp                 r_out;
    logic                          r_out_valid, n_out_valid;
    logic                          accept;
    logic                          res_ld;
    logic                          out_ld;
    logic [bfa_pkg::BIT_W-1:0]     zbit;
    logic [bfa_pkg::BIT_W-1:0]     cbit;

    assign accept = i_req_valid && !o_req_stall;
    assign out_ld = (r_state == bfa_pkg::S_DONE) && (!r_out_valid || !i_rsp_stall);
    assign cbit   = r_cur[bfa_pkg::BIT_W-1:0];

    assign o_words = (r_active >= bfa_pkg::CFG_W'(bfa_pkg::MAX_FRAMES))
        ? bfa_pkg::WCNT_W'(bfa_pkg::MAP_WORDS)
        : bfa_pkg::WCNT_W'(r_active >> bfa_pkg::BIT_W);

    always_comb begin
        zbit = '0;
        for (int b = bfa_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (!i_rd_data[b]) begin
                zbit = bfa_pkg::BIT_W'(b);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfa_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req.op == bfa_pkg::OP_ALLOC && i_req.current_frame == '0) begin
                        n_state = bfa_pkg::S_WORD;
                    end else if ((i_req.op == bfa_pkg::OP_FREE
                                  && i_req.current_frame != '0)
                                 || i_req.op == bfa_pkg::OP_TEST) begin
                        n_state = bfa_pkg::S_MODIFY;
                    end else begin
                        n_state = bfa_pkg::S_DONE;
                    end
                end
            end
            bfa_pkg::S_WORD: begin
                n_state = i_hit ? bfa_pkg::S_MODIFY : bfa_pkg::S_DONE;
            end
            bfa_pkg::S_MODIFY: begin
                n_state = bfa_pkg::S_DONE;
            end
            bfa_pkg::S_DONE: begin
                if (out_ld) begin
                    n_state = bfa_pkg::S_IDLE;
                end
            end
            default: n_state = bfa_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_word;
        o_wr_data   = i_rd_data;
        o_upd       = '0;
        res_ld      = 1'b0;
        n_res       = '0;
        o_req_stall = (r_state != bfa_pkg::S_IDLE);
        unique case (r_state)
            bfa_pkg::S_IDLE: begin
                o_rd_addr = i_req.current_frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
                if (accept) begin
                    res_ld = 1'b1;
                    n_res.frame_out = i_req.current_frame;
                    n_res.status    = bfa_pkg::ST_SKIP;
                    case (i_req.op)
                        bfa_pkg::OP_FREE: begin
                            o_rd_en = (i_req.current_frame != '0);
                            n_res.frame_out = '0;
                        end
                        bfa_pkg::OP_TEST: begin
                            o_rd_en = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            bfa_pkg::S_WORD: begin
                o_rd_addr = i_word;
                o_rd_en   = i_hit;
                if (!i_hit) begin
                    res_ld       = 1'b1;
                    n_res.status = bfa_pkg::ST_FULL;
                end
            end
            bfa_pkg::S_MODIFY: begin
                res_ld       = 1'b1;
                n_res.status = bfa_pkg::ST_DONE;
                case (r_op)
                    bfa_pkg::OP_ALLOC: begin
                        o_wr_en = 1'b1;
                        o_wr_data = i_rd_data
                            | (bfa_pkg::WORD_BITS'(1) << zbit);
                        n_res.frame_out   = {r_word, zbit};
                        n_res.present_bit = 1'b1;
                        n_res.rw_bit      = r_wr;
                        n_res.user_bit    = !r_kern;
                    end
                    bfa_pkg::OP_FREE: begin
                        o_wr_en = 1'b1;
                        o_wr_data = i_rd_data
                            & ~(bfa_pkg::WORD_BITS'(1) << cbit);
                    end
                    default: begin
                        n_res.frame_out = r_cur;
                        n_res.in_use    = i_rd_data[cbit];
                    end
                endcase
                o_upd.vld  = o_wr_en;
                o_upd.word = r_word;
                o_upd.full = &o_wr_data;
            end
            bfa_pkg::S_DONE: ;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_ld) begin
            n_out_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfa_pkg::S_IDLE;
            r_active    <= bfa_pkg::ACTIVE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.op;
            r_cur  <= i_req.current_frame;
            r_kern <= i_req.kernel_page;
            r_wr   <= i_req.writable;
            r_word <= i_req.current_frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
        end else if (r_state == bfa_pkg::S_WORD) begin
            r_word <= i_word;
        end
        if (res_ld) begin
            r_res <= n_res;
        end
        if (out_ld) begin
            r_out <= r_res;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_read_then_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |=> r_state == bfa_pkg::S_MODIFY)
        else $error("bitmap read not followed by update");

    a_write_in_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> r_state == bfa_pkg::S_MODIFY && r_op != bfa_pkg::OP_TEST)
        else $error("bitmap write outside update step");

    a_present_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bfa_pkg::S_DONE && r_res.present_bit |-> r_res.status == bfa_pkg::ST_DONE)
        else $error("allocation result with bad status");

    a_alloc_bit_was_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bfa_pkg::S_MODIFY && r_op == bfa_pkg::OP_ALLOC |-> !(&i_rd_data))
        else $error("allocation hit a full word");

endmodule
`default_nettype wire

### rtl/bitmap_frame_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit physical frame allocator over a used/free bitmap.
//
// One request is processed at a time. After acceptance, a skipped allocate, a
// free of frame zero and the unused op code go straight to the output
// register load. Free and test first pass a bitmap read, then an update. For
// an allocate with an empty entry, the word summary names the lowest word
// with a free frame, that word is read from the bitmap RAM, and the lowest
// zero bit is set and written back. When no word is free, the full status is
// loaded with no bitmap read or update. The input accepts again once the
// state returns to idle after the load. A held output register holds the
// result and stalls the input. The bitmap RAM read is registered. The bitmap
// is free after reset with no clearing pass: each RAM row has a valid bit.
// Write active_frames only while no request is in flight.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [bfa_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_req_valid,
    input  wire bfa_pkg::t_req             i_req,
    output logic                           o_req_stall,
    output logic                           o_rsp_valid,
    output bfa_pkg::t_rsp                  o_rsp,
    input  wire logic                      i_rsp_stall
);

    logic                          rd_en;
    logic [bfa_pkg::WORD_AW-1:0]   rd_addr;
    logic                          wr_en;
    logic [bfa_pkg::WORD_AW-1:0]   wr_addr;
    logic [bfa_pkg::WORD_BITS-1:0] wr_data;
    logic [bfa_pkg::WORD_BITS-1:0] rd_data;
    bfa_pkg::t_full_upd            upd;
    logic [bfa_pkg::WCNT_W-1:0]    words;
    logic                          hit;
    logic [bfa_pkg::WORD_AW-1:0]   word;

    bfa_map_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    bfa_free_find u_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .i_words (words),
        .o_hit   (hit),
        .o_word  (word)
    );

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data),
        .o_upd       (upd),
        .o_words     (words),
        .i_hit       (hit),
        .i_word      (word)
    );

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap frame allocator. A behavioral bitmap
// predicts every response when its request is accepted. Directed cases cover
// skips, frame zero, full maps and active-count limits. Random traffic runs
// under varied stalls on both channels, with long response hold-offs.
// ----------------------------------------------------------------------------
module testbench;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [bfa_pkg::CFG_W-1:0]   i_cfg_data;
    logic                        i_req_valid;
    bfa_pkg::t_req               i_req;
    logic                        o_req_stall;
    logic                        o_rsp_valid;
    bfa_pkg::t_rsp               o_rsp;
    logic                        i_rsp_stall;

    bit [bfa_pkg::MAX_FRAMES-1:0] frame_used;
    int unsigned                  active_count;
    bfa_pkg::t_rsp                pending_rsps[$];
    int                           errors;
    int                           tx_idle_pct;
    int                           rx_idle_pct;
    int                           hold_len;
    int                           hold_seq;
    int                           hold_ack;
    int                           hold_left;

    bitmap_frame_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // first-fit over whole 32-frame words below the clamped active count
    function automatic bfa_pkg::t_rsp predict_frame_op(input bfa_pkg::t_req r);
        bfa_pkg::t_rsp res;
        int unsigned   lim;
        int unsigned   span;
        bit            hit;
        res  = '0;
        hit  = 1'b0;
        case (r.op)
            bfa_pkg::OP_ALLOC: begin
                if (r.current_frame != '0) begin
                    res.frame_out = r.current_frame;
                    res.status    = bfa_pkg::ST_SKIP;
                end else begin
                    lim = active_count;
                    if (lim > bfa_pkg::MAX_FRAMES) lim = bfa_pkg::MAX_FRAMES;
                    if (lim > (1 << bfa_pkg::FRAME_W)) lim = 1 << bfa_pkg::FRAME_W;
                    span = (lim / bfa_pkg::WORD_BITS) * bfa_pkg::WORD_BITS;
                    for (int f = 0; f < span && !hit; f++) begin
                        if (!frame_used[f]) begin
                            hit             = 1'b1;
                            frame_used[f]   = 1'b1;
                            res.frame_out   = bfa_pkg::FRAME_W'(f);
                            res.present_bit = 1'b1;
                            res.rw_bit      = r.writable;
                            res.user_bit    = ~r.kernel_page;
                        end
                    end
                    if (!hit) res.status = bfa_pkg::ST_FULL;
                end
            end
            bfa_pkg::OP_FREE: begin
                if (r.current_frame == '0) res.status = bfa_pkg::ST_SKIP;
                else if (r.current_frame < bfa_pkg::MAX_FRAMES)
                    frame_used[r.current_frame] = 1'b0;
            end
            bfa_pkg::OP_TEST: begin
                res.frame_out = r.current_frame;
                if (r.current_frame < bfa_pkg::MAX_FRAMES)
                    res.in_use = frame_used[r.current_frame];
            end
            default: begin
                res.frame_out = r.current_frame;
                res.status    = bfa_pkg::ST_SKIP;
            end
        endcase
        return res;
    endfunction

    task automatic send_req(input logic [1:0] op, input int frame, input bit kern,
                            input bit wr);
        bfa_pkg::t_req r;
        r.op            = op;
        r.current_frame = bfa_pkg::FRAME_W'(frame);
        r.kernel_page   = kern;
        r.writable      = wr;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (o_req_stall);
        pending_rsps.push_back(predict_frame_op(r));
    endtask

    task automatic wait_results_idle();
        i_req_valid <= 1'b0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_active(input int unsigned value);
        wait_results_idle();
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= bfa_pkg::CFG_W'(value);
        @(posedge i_clk);
        active_count = value & ((1 << bfa_pkg::CFG_W) - 1);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        bfa_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (pending_rsps.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %p",
                         $time, o_rsp);
                errors++;
            end else begin
                want = pending_rsps.pop_front();
                check_field("frame_out", 32'(want.frame_out), 32'(o_rsp.frame_out));
                check_field("present_bit", 32'(want.present_bit),
                            32'(o_rsp.present_bit));
                check_field("rw_bit", 32'(want.rw_bit), 32'(o_rsp.rw_bit));
                check_field("user_bit", 32'(want.user_bit), 32'(o_rsp.user_bit));
                check_field("status", 32'(want.status), 32'(o_rsp.status));
                check_field("in_use", 32'(want.in_use), 32'(o_rsp.in_use));
            end
        end
    end

    // response stall: random, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_seq != hold_ack) begin
            hold_left = hold_len;
            hold_ack  = hold_seq;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic test_directed();
        send_req(bfa_pkg::OP_TEST,  0,    1'b0, 1'b0);
        send_req(bfa_pkg::OP_ALLOC, 0,    1'b0, 1'b1);
        send_req(bfa_pkg::OP_ALLOC, 0,    1'b1, 1'b0);
        send_req(bfa_pkg::OP_ALLOC, 4095, 1'b1, 1'b1);
        send_req(bfa_pkg::OP_ALLOC, 1,    1'b0, 1'b0);
        send_req(bfa_pkg::OP_TEST,  0,    1'b1, 1'b1);
        send_req(bfa_pkg::OP_TEST,  1,    1'b0, 1'b0);
        send_req(bfa_pkg::OP_TEST,  4095, 1'b0, 1'b0);
        send_req(bfa_pkg::OP_FREE,  0,    1'b1, 1'b1);
        send_req(bfa_pkg::OP_FREE,  1,    1'b0, 1'b0);
        send_req(bfa_pkg::OP_FREE,  4095, 1'b0, 1'b0);
        send_req(bfa_pkg::OP_RSVD,  4095, 1'b1, 1'b1);
        send_req(bfa_pkg::OP_RSVD,  0,    1'b0, 1'b0);
        send_req(bfa_pkg::OP_ALLOC, 0,    1'b1, 1'b1);
        send_req(bfa_pkg::OP_TEST,  2048, 1'b0, 1'b0);
    endtask

    task automatic test_active_limits();
        write_active(0);
        send_req(bfa_pkg::OP_ALLOC, 0, 1'b0, 1'b0);
        send_req(bfa_pkg::OP_FREE,  1, 1'b0, 1'b0);
        write_active(31);
        send_req(bfa_pkg::OP_ALLOC, 0, 1'b1, 1'b1);
        write_active(32);
        send_req(bfa_pkg::OP_ALLOC, 0, 1'b0, 1'b1);
        send_req(bfa_pkg::OP_TEST,  1, 1'b0, 1'b0);
        write_active(8191);
        send_req(bfa_pkg::OP_ALLOC, 0, 1'b1, 1'b0);
        write_active(32'(bfa_pkg::ACTIVE_RESET));
        send_req(bfa_pkg::OP_ALLOC, 0, 1'b0, 1'b1);
    endtask

    task automatic send_random(input int unsigned pick_span);
        int unsigned sel;
        bit          kern;
        bit          wr;
        sel  = $urandom_range(99);
        kern = 1'($urandom_range(1));
        wr   = 1'($urandom_range(1));
        if (sel < 45)
            send_req(bfa_pkg::OP_ALLOC, 0, kern, wr);
        else if (sel < 50)
            send_req(bfa_pkg::OP_ALLOC, $urandom_range(4095, 1), kern, wr);
        else if (sel < 75)
            send_req(bfa_pkg::OP_FREE, $urandom_range(pick_span - 1), kern, wr);
        else if (sel < 78)
            send_req(bfa_pkg::OP_FREE, $urandom_range(4095), kern, wr);
        else if (sel < 90)
            send_req(bfa_pkg::OP_TEST, $urandom_range(pick_span - 1), kern, wr);
        else if (sel < 94)
            send_req(bfa_pkg::OP_TEST, $urandom_range(4095), kern, wr);
        else
            send_req(bfa_pkg::OP_RSVD, $urandom_range(4095), kern, wr);
    endtask

    task automatic test_random_traffic(input int n, input int tx_pct, input int rx_pct,
                                       input int unsigned active);
        int unsigned pick_span;
        write_active(active);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        pick_span   = (active / bfa_pkg::WORD_BITS) * bfa_pkg::WORD_BITS;
        if (pick_span > 256) pick_span = 256;
        if (pick_span < bfa_pkg::WORD_BITS) pick_span = bfa_pkg::WORD_BITS;
        for (int i = 0; i < n; i++) begin
            send_random(pick_span);
            if ($urandom_range(99) == 0) wait_results_idle();
        end
    endtask

    task automatic test_backpressure();
        wait_results_idle();
        @(posedge i_clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len    = 300;
        hold_seq++;
        for (int i = 0; i < 30; i++) send_random(64);
        wait_results_idle();
    endtask

    initial begin
        errors       = 0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_len     = 0;
        hold_seq     = 0;
        hold_ack     = 0;
        hold_left    = 0;
        frame_used   = '0;
        active_count = 32'(bfa_pkg::ACTIVE_RESET);
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_rsp_stall <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_active_limits();
        test_random_traffic(240, 13, 74, 64);
        test_random_traffic(240, 74, 13, $urandom_range(320, 32));
        test_random_traffic(240, 0, 0, 32'(bfa_pkg::ACTIVE_RESET));
        test_backpressure();

        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_rsps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
